@@ rtl/rpd_pkg.sv @@
// Package for the rc pulse train decoder: item types, register indexes and constants.
package rpd_pkg;

  // Number of channels in one frame (5 to 7)
  localparam int CHANNELS = 7;
  // Edge and channel byte stores are sized for the largest frame
  localparam int STORE_DEPTH = 7;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] LAST_PHASE = IDX_W'(CHANNELS);
  // Channel that completes the checked group, and first unchecked aux channel
  localparam logic [IDX_W-1:0] CHECK_CH = 3'd4;
  localparam logic [IDX_W-1:0] AUX_FIRST_CH = 3'd5;

  // Channel byte slots
  localparam int CB_THROTTLE = 0;
  localparam int CB_ROLL = 1;
  localparam int CB_PITCH = 2;
  localparam int CB_YAW = 3;
  localparam int CB_AUX5 = 4;
  localparam int CB_AUX6 = 5;
  localparam int CB_AUX7 = 6;

  // Operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_POLARITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_CHANNEL_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT = 3'd4;

  // Register reset values
  localparam logic [7:0] NEUTRAL_RESET = 8'd128;
  localparam logic [15:0] SHORT_TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] LONG_TIMEOUT_RESET = 16'd14000;

  // Valid channel widths have this upper byte (256..511)
  localparam logic [7:0] WIDTH_HIGH_OK = 8'd1;

  typedef struct packed {
    logic        operation;
    logic [15:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        throttle;
    logic signed [7:0] roll;
    logic signed [7:0] pitch;
    logic signed [7:0] yaw;
    logic [7:0]        aux_five;
    logic [7:0]        aux_six;
    logic [7:0]        aux_seven;
    logic              signal_lost;
    logic              frame_ready;
    logic              next_edge_select;
    logic [2:0]        edge_phase;
  } out_item_t;

endpackage

@@ rtl/rc_pulse_train_decoder.sv @@
// Receiver pulse train decoder: edge captures and timebase ticks in, channel bytes out.
//
// Each input item is either an edge capture (operation 0, carrying the latched
// 16-bit timer value) or one timebase tick (operation 1), and yields exactly one
// result item with the current channel bytes, signal_lost, a frame_ready strobe,
// the edge select the capture unit should arm next and the next expected edge
// index. Items pass through an input register and a result register with the
// decode logic between them, so the block takes one item per clock while
// out_stall is low; a stalled result holds the item in the input register.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no item is in flight. After reset the signal is
// flagged lost until the first frame with channels one to five in 256..511.
module rc_pulse_train_decoder
  import rpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic        neg_pol_r;
  logic        alt_order_r;
  logic [7:0]  neutral_r;
  logic [15:0] short_to_r;
  logic [15:0] long_to_r;

  // Pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;

  // Decoder state
  logic [15:0] edge_store_r [STORE_DEPTH];
  logic [15:0] edge_store_nxt [STORE_DEPTH];
  logic [7:0]  chan_bytes_r [STORE_DEPTH];
  logic [7:0]  chan_bytes_nxt [STORE_DEPTH];
  logic [2:0]  phase_r, phase_nxt;
  logic        edge_sel_r, edge_sel_nxt;
  logic        first_to_r, first_to_nxt;
  logic        long_per_r, long_per_nxt;
  logic [15:0] to_count_r, to_count_nxt;
  logic        lost_r, lost_nxt;
  logic        ready_nxt;

  // Decode intermediates
  logic [2:0]  ch;
  logic [15:0] diff;
  logic [14:0] width;
  logic        leading;
  logic        range_ok;
  logic        err;
  logic [15:0] tick_count;
  logic [15:0] period;
  logic [15:0] thr_w, rol_w, pit_w;

  // Handshake: the input register moves on whenever the result slot frees up
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_pol_r   <= 1'b0;
      alt_order_r <= 1'b0;
      neutral_r   <= NEUTRAL_RESET;
      short_to_r  <= SHORT_TIMEOUT_RESET;
      long_to_r   <= LONG_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEGATIVE_POLARITY: neg_pol_r   <= cfg_wdata[0];
        CFG_ALT_CHANNEL_ORDER: alt_order_r <= cfg_wdata[0];
        CFG_NEUTRAL_OFFSET:    neutral_r   <= cfg_wdata[7:0];
        CFG_SHORT_TIMEOUT:     short_to_r  <= cfg_wdata[15:0];
        CFG_LONG_TIMEOUT:      long_to_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // Per-item decode
  always_comb begin
    edge_store_nxt = edge_store_r;
    chan_bytes_nxt = chan_bytes_r;
    phase_nxt      = phase_r;
    edge_sel_nxt   = edge_sel_r;
    first_to_nxt   = first_to_r;
    long_per_nxt   = long_per_r;
    to_count_nxt   = to_count_r;
    lost_nxt       = lost_r;
    ready_nxt      = 1'b0;
    err            = 1'b0;

    ch       = phase_r - 3'd1;
    diff     = in_item_r.capture_time - edge_store_r[ch];
    width    = diff[15:1];
    leading  = neg_pol_r ^ ~edge_sel_r;
    range_ok = (edge_store_r[0][15:8] == WIDTH_HIGH_OK) &&
               (edge_store_r[1][15:8] == WIDTH_HIGH_OK) &&
               (edge_store_r[2][15:8] == WIDTH_HIGH_OK) &&
               (edge_store_r[3][15:8] == WIDTH_HIGH_OK) &&
               ({1'b0, width[14:8]} == WIDTH_HIGH_OK);
    thr_w    = alt_order_r ? edge_store_r[2] : edge_store_r[0];
    rol_w    = alt_order_r ? edge_store_r[0] : edge_store_r[1];
    pit_w    = alt_order_r ? edge_store_r[1] : edge_store_r[2];

    tick_count = to_count_r + 16'd1;
    period     = long_per_r ? long_to_r : short_to_r;

    if (in_item_r.operation == OP_TICK) begin
      // Two stage timeout
      to_count_nxt = tick_count;
      if (tick_count >= period) begin
        to_count_nxt = 16'd0;
        if (first_to_r) begin
          long_per_nxt = 1'b0;
          lost_nxt     = 1'b1;
          phase_nxt    = 3'd0;
          edge_sel_nxt = neg_pol_r;
        end else begin
          first_to_nxt = 1'b1;
          long_per_nxt = 1'b1;
          phase_nxt    = 3'd0;
        end
      end
    end else begin
      // Edge capture
      to_count_nxt = 16'd0;
      first_to_nxt = 1'b0;
      long_per_nxt = 1'b0;
      edge_sel_nxt = ~edge_sel_r;
      if (phase_r > LAST_PHASE || leading != ~phase_r[0]) begin
        err = 1'b1;
      end else begin
        if (phase_r != 3'd0) begin
          // Channel width ends here; stored even if the range check fails
          edge_store_nxt[ch] = {1'b0, width};
          if (ch >= AUX_FIRST_CH) begin
            chan_bytes_nxt[ch] = width[7:0];
          end else if (ch == CHECK_CH) begin
            if (!range_ok) begin
              err = 1'b1;
            end else begin
              chan_bytes_nxt[CB_THROTTLE] = thr_w[7:0];
              chan_bytes_nxt[CB_ROLL]     = rol_w[7:0] - neutral_r;
              chan_bytes_nxt[CB_PITCH]    = pit_w[7:0] - neutral_r;
              chan_bytes_nxt[CB_YAW]      = edge_store_r[3][7:0] - neutral_r;
              chan_bytes_nxt[CB_AUX5]     = width[7:0];
              lost_nxt                    = 1'b0;
              ready_nxt                   = 1'b1;
            end
          end
        end
        if (!err) begin
          if (phase_r == LAST_PHASE) begin
            phase_nxt = 3'd0;
          end else begin
            edge_store_nxt[phase_r] = in_item_r.capture_time;
            phase_nxt               = phase_r + 3'd1;
          end
        end
      end
      // Error restart
      if (err) begin
        lost_nxt     = 1'b1;
        phase_nxt    = 3'd0;
        edge_sel_nxt = neg_pol_r;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 3'd0;
      edge_sel_r  <= 1'b0;
      first_to_r  <= 1'b0;
      long_per_r  <= 1'b0;
      to_count_r  <= 16'd0;
      lost_r      <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        edge_store_r[i] <= 16'd0;
        chan_bytes_r[i] <= 8'd0;
      end
    end else begin
      if (advance) begin
        phase_r        <= phase_nxt;
        edge_sel_r     <= edge_sel_nxt;
        first_to_r     <= first_to_nxt;
        long_per_r     <= long_per_nxt;
        to_count_r     <= to_count_nxt;
        lost_r         <= lost_nxt;
        edge_store_r   <= edge_store_nxt;
        chan_bytes_r   <= chan_bytes_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.throttle         <= chan_bytes_nxt[CB_THROTTLE];
      out_item_r.roll             <= chan_bytes_nxt[CB_ROLL];
      out_item_r.pitch            <= chan_bytes_nxt[CB_PITCH];
      out_item_r.yaw              <= chan_bytes_nxt[CB_YAW];
      out_item_r.aux_five         <= chan_bytes_nxt[CB_AUX5];
      out_item_r.aux_six          <= chan_bytes_nxt[CB_AUX6];
      out_item_r.aux_seven        <= chan_bytes_nxt[CB_AUX7];
      out_item_r.signal_lost      <= lost_nxt;
      out_item_r.frame_ready      <= ready_nxt;
      out_item_r.next_edge_select <= edge_sel_nxt;
      out_item_r.edge_phase       <= phase_nxt;
    end
  end

endmodule
